// ----- rtl/ebad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebad_pkg: shared definitions for the emulated bus access decoder
// Memory geometry, address map constants, access codes and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ebad_pkg;

	// Bytes of physical RAM behind the decoder.
	localparam int unsigned MEM_BYTES = 1048576;
	// The RAM is two byte banks side by side, one 16-bit row per even address.
	localparam int unsigned RAM_ROWS  = MEM_BYTES / 2;
	localparam int unsigned ROW_AW    = $clog2(RAM_ROWS);
	localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

	// Configuration register.
	localparam int unsigned RAM_SIZE_W = 21;
	localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RST = 21'd1048576;

	// Address map.
	localparam logic [7:0]  MIRROR_TOP  = 8'hFF;
	localparam logic [31:0] LOW24_MASK  = 32'h00FF_FFFF;
	localparam logic [31:0] IO_LOW      = 32'h00FF_8000;
	localparam logic [31:0] IO_END      = 32'h0100_0000;
	localparam logic [31:0] IO_IERB     = 32'h00FF_FA09;
	localparam logic [31:0] IO_KBD_CTRL = 32'h00FF_FC00;
	localparam logic [7:0]  IERB_VAL    = 8'h40;
	localparam logic [7:0]  KBD_VAL     = 8'h03;

	// Access codes.
	localparam logic       CMD_READ  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;      // clearing sweep writes one zero row
		logic load;     // capture the accepted item
		logic acc;      // issue one 16-bit RAM access
		logic phase;    // second row of a long access
		logic hold;     // keep the first row of a long read
		logic out_load; // load the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;   // sweep is at the last row
		logic is_long;    // item is a long access
		logic misaligned; // word or long at an odd address
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ebad_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebad_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module ebad_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array and read register.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ebad_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebad_datapath: address decode, RAM banks and result assembly
// Holds the item, decodes one even-aligned 16-bit row per access, drives the
// two byte banks and builds the right-aligned read value.
// ----------------------------------------------------------------------------
module ebad_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ebad_pkg::dp_cmd_t               cmd,
	output ebad_pkg::dp_sts_t                    sts,
	input  wire logic                            command,
	input  wire logic [1:0]                      access_size,
	input  wire logic [31:0]                     address,
	input  wire logic [31:0]                     write_data,
	input  wire logic                            ram_size_we,
	input  wire logic [ebad_pkg::RAM_SIZE_W-1:0] ram_size,
	output logic      [31:0]                     read_data,
	output logic                                 status
);

	logic                            cmd_q;
	logic [1:0]                      size_q;
	logic [31:0]                     addr_q;
	logic [31:0]                     wd_q;
	logic [ebad_pkg::RAM_SIZE_W-1:0] ram_size_q;
	logic [ebad_pkg::ROW_AW-1:0]     row_cnt_q;

	logic [31:0] word_addr;
	logic [31:0] stripped;
	logic [31:0] limit;
	logic [31:0] size_ext;
	logic        io;
	logic        hit_hi;
	logic        hit_lo;
	logic [7:0]  stub_hi;
	logic [7:0]  stub_lo;
	logic        is_byte;
	logic        is_long;
	logic        en_hi;
	logic        en_lo;
	logic        wr;
	logic        bank_en;
	logic [ebad_pkg::ROW_AW-1:0] bank_addr;
	logic [7:0]  wd_hi;
	logic [7:0]  wd_lo;
	logic [7:0]  rd_hi;
	logic [7:0]  rd_lo;

	logic        io_s1;
	logic        hit_hi_s1;
	logic        hit_lo_s1;
	logic [7:0]  stub_hi_s1;
	logic [7:0]  stub_lo_s1;
	logic [15:0] word_val;
	logic [15:0] hold_q;
	logic [31:0] result;
	logic [31:0] read_data_q;
	logic        status_q;

	// Configuration register and clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= ebad_pkg::RAM_SIZE_RST;
			row_cnt_q  <= '0;
		end else begin
			if (ram_size_we) begin
				ram_size_q <= ram_size;
			end
			if (cmd.clr) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			size_q <= access_size;
			addr_q <= address;
			wd_q   <= write_data;
		end
	end

	assign is_byte = (size_q == ebad_pkg::SIZE_BYTE);
	assign is_long = size_q[1];

	// Decode of the current row: mirror strip, I/O window and RAM limit.
	always_comb begin
		word_addr = {addr_q[31:1], 1'b0} + (cmd.phase ? 32'd2 : 32'd0);
		stripped  = (word_addr[31:24] == ebad_pkg::MIRROR_TOP) ?
			(word_addr & ebad_pkg::LOW24_MASK) : word_addr;
		io        = (stripped >= ebad_pkg::IO_LOW) && (stripped < ebad_pkg::IO_END);
		size_ext  = 32'(ram_size_q);
		limit     = (size_ext < ebad_pkg::MEM_LIMIT) ? size_ext : ebad_pkg::MEM_LIMIT;
		hit_hi    = !io && (stripped < limit);
		hit_lo    = !io && ((stripped | 32'd1) < limit);
		stub_hi   = (stripped == ebad_pkg::IO_KBD_CTRL) ? ebad_pkg::KBD_VAL : 8'h00;
		stub_lo   = ((stripped | 32'd1) == ebad_pkg::IO_IERB) ? ebad_pkg::IERB_VAL : 8'h00;
	end

	// Byte lanes and write data of the current row.
	always_comb begin
		en_hi = is_byte ? !addr_q[0] : 1'b1;
		en_lo = is_byte ? addr_q[0] : 1'b1;
		wr    = cmd.acc && (cmd_q == ebad_pkg::CMD_WRITE);
		if (is_byte) begin
			wd_hi = wd_q[7:0];
			wd_lo = wd_q[7:0];
		end else if (is_long && !cmd.phase) begin
			wd_hi = wd_q[31:24];
			wd_lo = wd_q[23:16];
		end else begin
			wd_hi = wd_q[15:8];
			wd_lo = wd_q[7:0];
		end
		bank_en   = cmd.clr || cmd.acc;
		bank_addr = cmd.clr ? row_cnt_q : stripped[ebad_pkg::ROW_AW:1];
	end

	// High byte bank holds even addresses.
	ebad_ram #(
		.WIDTH (8),
		.DEPTH (ebad_pkg::RAM_ROWS)
	) u_bank_hi (
		.clk   (clk),
		.en    (bank_en),
		.we    (cmd.clr || (wr && hit_hi && en_hi)),
		.addr  (bank_addr),
		.wdata (cmd.clr ? 8'h00 : wd_hi),
		.rdata (rd_hi)
	);

	// Low byte bank holds odd addresses.
	ebad_ram #(
		.WIDTH (8),
		.DEPTH (ebad_pkg::RAM_ROWS)
	) u_bank_lo (
		.clk   (clk),
		.en    (bank_en),
		.we    (cmd.clr || (wr && hit_lo && en_lo)),
		.addr  (bank_addr),
		.wdata (cmd.clr ? 8'h00 : wd_lo),
		.rdata (rd_lo)
	);

	// Decode flags are registered with the RAM read so they line up with its data.
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			io_s1      <= io;
			hit_hi_s1  <= hit_hi;
			hit_lo_s1  <= hit_lo;
			stub_hi_s1 <= stub_hi;
			stub_lo_s1 <= stub_lo;
		end
	end

	// Row value as seen on the bus: stub, RAM byte or zero.
	always_comb begin
		word_val[15:8] = io_s1 ? stub_hi_s1 : (hit_hi_s1 ? rd_hi : 8'h00);
		word_val[7:0]  = io_s1 ? stub_lo_s1 : (hit_lo_s1 ? rd_lo : 8'h00);
	end

	// First row of a long read waits here for the second.
	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			hold_q <= word_val;
		end
	end

	assign sts.clr_last   = (row_cnt_q == ebad_pkg::ROW_AW'(ebad_pkg::RAM_ROWS - 1));
	assign sts.is_long    = is_long;
	assign sts.misaligned = !is_byte && addr_q[0];

	// Result assembly.
	always_comb begin
		if (sts.misaligned || (cmd_q == ebad_pkg::CMD_WRITE)) begin
			result = 32'h0;
		end else if (is_byte) begin
			result = {24'h0, (addr_q[0] ? word_val[7:0] : word_val[15:8])};
		end else if (is_long) begin
			result = {hold_q, word_val};
		end else begin
			result = {16'h0, word_val};
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q <= result;
			status_q    <= sts.misaligned;
		end
	end

	assign read_data = read_data_q;
	assign status    = status_q;

endmodule
`default_nettype wire

// ----- rtl/ebad_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebad_ctrl: sequencing controller
// Runs the clearing sweep after reset, then steps each item through one or
// two RAM row accesses (none if misaligned) and loads the output register.
// ----------------------------------------------------------------------------
module ebad_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ebad_pkg::dp_cmd_t      cmd,
	input  wire ebad_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC0,
		ST_ACC1,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Commands decoded from the state.
	always_comb begin
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.acc      = ((state_q == ST_ACC0) && !sts.misaligned) || (state_q == ST_ACC1);
		cmd.phase    = (state_q == ST_ACC1);
		cmd.hold     = (state_q == ST_ACC1);
		cmd.out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ACC0;
					end
				end
				ST_ACC0: begin
					if (!sts.misaligned && sts.is_long) begin
						state_q <= ST_ACC1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_ACC1: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/emulated_bus_access_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// emulated_bus_access_decoder_core: big-endian CPU bus access decoder
// Serves byte, word and long reads and writes on a byte-addressed RAM with a
// mirrored top byte, a stubbed I/O window and a configurable RAM size.
//
//   Channel   Direction  Handshake             Payload
//   in        sink       in_valid / in_stall   command, access_size, address,
//                                              write_data
//   out       source     out_valid / out_stall read_data, status
//   config    sink       ram_size_we           ram_size
//
// Each item steps through an access state, a second one for a long, and a
// finishing state before the next is taken; a misaligned item makes no RAM
// access. The RAM is a pair of byte banks with one 16-bit row per access
// and a registered read, so a long needs two rows. After reset the block
// sweeps all MEM_BYTES/2 rows (524288 as built) to zero, one row a cycle, with
// in_stall high; configuration writes are taken meanwhile. A finished result
// sits in the output register, so a stalled output holds only the item after it.
// ----------------------------------------------------------------------------
module emulated_bus_access_decoder_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            command,
	input  wire logic [1:0]                      access_size,
	input  wire logic [31:0]                     address,
	input  wire logic [31:0]                     write_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [31:0]                     read_data,
	output logic                                 status,
	input  wire logic                            ram_size_we,
	input  wire logic [ebad_pkg::RAM_SIZE_W-1:0] ram_size
);

	ebad_pkg::dp_cmd_t cmd;
	ebad_pkg::dp_sts_t sts;

	// Sequencing controller.
	ebad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Decode, storage and result datapath.
	ebad_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (command),
		.access_size (access_size),
		.address     (address),
		.write_data  (write_data),
		.ram_size_we (ram_size_we),
		.ram_size    (ram_size),
		.read_data   (read_data),
		.status      (status)
	);

endmodule
`default_nettype wire

// ----- rtl/ebad_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebad_checker: port-level checks for the bus access decoder
// Watches the top-level ports for item spacing and result consistency.
// ----------------------------------------------------------------------------
module ebad_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        command,
	input wire logic [1:0]  access_size,
	input wire logic [31:0] address,
	input wire logic [31:0] write_data,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] read_data,
	input wire logic        status
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
		else $error("stalled result changed");

	// A misaligned access never returns data.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_data == 32'h0)
		else $error("misaligned result carries data");

	// Every accepted item holds in_stall high while the block is busy with it.
	a_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("item accepted too soon after the previous one");

	// A stalled input item stays offered and keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(command) && $stable(access_size)
			&& $stable(address) && $stable(write_data))
		else $error("stalled input item changed");

endmodule

bind emulated_bus_access_decoder_core ebad_checker u_ebad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.command     (command),
	.access_size (access_size),
	.address     (address),
	.write_data  (write_data),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.read_data   (read_data),
	.status      (status)
);
`default_nettype wire
